// ----- hdl/window_bisect_line_simplifier_macros.svh -----
// ----------------------------------------------------------------------------
// window bisect line simplifier assertion macros
// shared concurrent assertion forms for the simplifier rtl
// ----------------------------------------------------------------------------
`ifndef WINDOW_BISECT_LINE_SIMPLIFIER_MACROS_SVH
`define WINDOW_BISECT_LINE_SIMPLIFIER_MACROS_SVH

// condition implies consequence in the same cycle
`define WBLS_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define WBLS_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/wbls_pkg.sv -----
// ----------------------------------------------------------------------------
// wbls package
// shared types and constants of the window bisect line simplifier
// ----------------------------------------------------------------------------
package wbls_pkg;

   localparam int IDX_W   = 6;
   localparam int CNT_W   = 7;
   localparam int TIME_W  = 22;
   localparam int VAL_W   = 32;
   localparam int DELTA_W = 16;
   localparam int EPS_W   = 31;
   localparam int STACK_DEPTH = 8;
   localparam int SP_W    = 4;

   localparam logic [1:0] CSR_WINDOW_LEN = 2'd0;
   localparam logic [1:0] CSR_EPSILON    = 2'd1;

   // one stored sample on its way from front to back
   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [TIME_W-1:0] time_abs;
      logic [VAL_W-1:0]  value;
      logic              close;
   } sample_type;

   typedef struct packed {
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
   } segment_type;

endpackage

// ----- hdl/wbls_queue.sv -----
// ----------------------------------------------------------------------------
// wbls queue
// two-entry sample queue between front and back
// ----------------------------------------------------------------------------
module wbls_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  wbls_pkg::sample_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output wbls_pkg::sample_type pop_data
);
   import wbls_pkg::*;

   sample_type  entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/wbls_front.sv -----
// ----------------------------------------------------------------------------
// wbls front
// accepts samples, accumulates time, decides where a window closes
// ----------------------------------------------------------------------------
module wbls_front #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [wbls_pkg::CNT_W-1:0]    window_len,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [wbls_pkg::DELTA_W-1:0]  time_delta,
   input  logic [wbls_pkg::VAL_W-1:0]    sample_value,
   input  logic                          end_window,
   output logic                          push,
   output wbls_pkg::sample_type          push_data,
   input  logic                          full
);
   import wbls_pkg::*;

   localparam logic [CNT_W-1:0] MaxLen = CNT_W'(MAX_WINDOW);

   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [TIME_W-1:0] prev_time_ff, prev_time_in;
   logic [CNT_W-1:0]  eff_len;
   logic [CNT_W-1:0]  fill_next;

   always_comb begin
      if (window_len < CNT_W'(2)) begin
         eff_len = CNT_W'(2);
      end else if (window_len > MaxLen) begin
         eff_len = MaxLen;
      end else begin
         eff_len = window_len;
      end
   end

   assign in_ready = !full;
   assign push     = in_valid && in_ready;

   always_comb begin
      fill_next          = fill_ff + CNT_W'(1);
      push_data.idx      = fill_ff[IDX_W-1:0];
      push_data.time_abs = (fill_ff == '0) ? '0 : prev_time_ff + TIME_W'(time_delta);
      push_data.value    = sample_value;
      push_data.close    = end_window || (fill_next >= eff_len);
      fill_in            = fill_ff;
      prev_time_in       = prev_time_ff;
      if (push) begin
         fill_in      = push_data.close ? '0 : fill_next;
         prev_time_in = push_data.time_abs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_time_ff <= prev_time_in;
   end

endmodule

// ----- hdl/wbls_back.sv -----
// ----------------------------------------------------------------------------
// wbls back
// stores samples, bisects the closed window, emits kept samples
// ----------------------------------------------------------------------------
`include "window_bisect_line_simplifier_macros.svh"

module wbls_back #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [wbls_pkg::EPS_W-1:0]    epsilon,
   input  logic                          empty,
   input  wbls_pkg::sample_type          pop_data,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [wbls_pkg::VAL_W-1:0]    kept_value,
   output logic [wbls_pkg::IDX_W-1:0]    kept_index,
   output logic                          last_kept
);
   import wbls_pkg::*;

   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   typedef enum logic [10:0] {
      ST_IDLE = 11'b00000000001,
      ST_POP  = 11'b00000000010,
      ST_RDAB = 11'b00000000100,
      ST_LDAB = 11'b00000001000,
      ST_RDI  = 11'b00000010000,
      ST_LDI  = 11'b00000100000,
      ST_MUL  = 11'b00001000000,
      ST_CMP  = 11'b00010000000,
      ST_SCAN = 11'b00100000000,
      ST_RDO  = 11'b01000000000,
      ST_OUT  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [VAL_W-1:0]  val_mem [MAX_WINDOW];
   logic [TIME_W-1:0] time_mem [MAX_WINDOW];
   logic [VAL_W-1:0]  rd_val_a_ff, rd_val_b_ff;
   logic [TIME_W-1:0] rd_time_a_ff, rd_time_b_ff;
   logic [AW-1:0]     addr_a, addr_b;

   segment_type       stack_ff [STACK_DEPTH];
   segment_type       stack_wr0, stack_wr1;
   logic              stack_we0, stack_we1;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic [MAX_WINDOW-1:0] keep_ff, keep_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic [IDX_W-1:0]  mid;

   logic [TIME_W-1:0] ta_ff, ta_in;
   logic [VAL_W-1:0]  va_ff, va_in;
   logic [TIME_W-1:0] dx_ff, dx_in;
   logic signed [VAL_W:0]  dy_ff, dy_in;
   logic signed [VAL_W:0]  dv_ff, dv_in;
   logic signed [TIME_W:0] dt_ff, dt_in;
   logic signed [VAL_W+TIME_W+1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic [EPS_W+TIME_W-1:0] lim_ff, lim_in;
   logic signed [VAL_W+TIME_W+2:0] num;
   logic [VAL_W+TIME_W+2:0] num_abs;

   logic              out_valid_ff, out_valid_in;
   logic [VAL_W-1:0]  out_value_ff, out_value_in;
   logic [IDX_W-1:0]  out_index_ff, out_index_in;
   logic              out_last_ff, out_last_in;
   logic [MAX_WINDOW-1:0] keep_hi;
   logic              split;

   assign out_valid  = out_valid_ff;
   assign kept_value = out_value_ff;
   assign kept_index = out_index_ff;
   assign last_kept  = out_last_ff;

   assign mid     = IDX_W'(({1'b0, a_ff} + {1'b0, b_ff}) >> 1);
   assign num     = {p1_ff[VAL_W+TIME_W+1], p1_ff} - {p2_ff[VAL_W+TIME_W+1], p2_ff};
   assign num_abs = num[VAL_W+TIME_W+2] ? (~num + 1'b1) : num;
   assign keep_hi = keep_ff >> i_ff[IDX_W-1:0];

   always_comb begin
      addr_a = a_ff[AW-1:0];
      addr_b = b_ff[AW-1:0];
      if (state_ff == ST_RDI || state_ff == ST_SCAN) begin
         addr_a = i_ff[AW-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      pop          = 1'b0;
      sp_in        = sp_ff;
      keep_in      = keep_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      ta_in        = ta_ff;
      va_in        = va_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dv_in        = dv_ff;
      dt_in        = dt_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      lim_in       = lim_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_index_in = out_index_ff;
      out_last_in  = out_last_ff;
      stack_we0    = 1'b0;
      stack_we1    = 1'b0;
      stack_wr0    = '{a: mid, b: b_ff};
      stack_wr1    = '{a: a_ff, b: mid};
      split        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               if (pop_data.close) begin
                  n_in      = CNT_W'(pop_data.idx) + CNT_W'(1);
                  keep_in   = '0;
                  stack_wr0 = '{a: '0, b: pop_data.idx};
                  stack_we0 = 1'b1;
                  sp_in     = SP_W'(1);
                  state_in  = ST_POP;
               end
            end
         end
         ST_POP: begin
            if (sp_ff == '0) begin
               i_in     = '0;
               state_in = ST_SCAN;
            end else begin
               a_in    = stack_ff[sp_ff[SP_W-2:0] - 1'b1].a;
               b_in    = stack_ff[sp_ff[SP_W-2:0] - 1'b1].b;
               sp_in   = sp_ff - SP_W'(1);
               keep_in = keep_ff | (MAX_WINDOW'(1) << a_in) | (MAX_WINDOW'(1) << b_in);
               if (CNT_W'(a_in) + CNT_W'(1) < CNT_W'(b_in)) begin
                  state_in = ST_RDAB;
               end
            end
         end
         ST_RDAB: begin
            state_in = ST_LDAB;
         end
         ST_LDAB: begin
            ta_in = rd_time_a_ff;
            va_in = rd_val_a_ff;
            dx_in = (rd_time_b_ff >= rd_time_a_ff) ? rd_time_b_ff - rd_time_a_ff
                                                    : rd_time_a_ff - rd_time_b_ff;
            dy_in = $signed({rd_val_b_ff[VAL_W-1], rd_val_b_ff})
                  - $signed({rd_val_a_ff[VAL_W-1], rd_val_a_ff});
            i_in  = CNT_W'(a_ff) + CNT_W'(1);
            if (rd_time_a_ff == rd_time_b_ff) begin
               split = 1'b1;
            end else begin
               state_in = ST_RDI;
            end
         end
         ST_RDI: begin
            lim_in   = epsilon * dx_ff;
            state_in = ST_LDI;
         end
         ST_LDI: begin
            dv_in    = $signed({rd_val_a_ff[VAL_W-1], rd_val_a_ff})
                     - $signed({va_ff[VAL_W-1], va_ff});
            dt_in    = $signed({1'b0, rd_time_a_ff}) - $signed({1'b0, ta_ff});
            state_in = ST_MUL;
         end
         ST_MUL: begin
            p1_in    = dv_ff * $signed({1'b0, dx_ff});
            p2_in    = dy_ff * dt_ff;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (num_abs > (VAL_W+TIME_W+3)'(lim_ff)) begin
               split = 1'b1;
            end else if (i_ff + CNT_W'(1) < CNT_W'(b_ff)) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_RDI;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_SCAN: begin
            if (i_ff == n_ff) begin
               keep_in  = '0;
               state_in = ST_IDLE;
            end else if (keep_ff[i_ff[AW-1:0]]) begin
               state_in = ST_RDO;
            end else begin
               i_in = i_ff + CNT_W'(1);
            end
         end
         ST_RDO: begin
            out_valid_in = 1'b1;
            out_value_in = rd_val_a_ff;
            out_index_in = i_ff[IDX_W-1:0];
            out_last_in  = (keep_hi >> 1) == '0;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (out_ready) begin
               out_valid_in = 1'b0;
               i_in         = i_ff + CNT_W'(1);
               state_in     = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // split pushes the right half first so the left half pops next
      if (split) begin
         state_in = ST_POP;
         if (sp_ff < SP_W'(STACK_DEPTH)) begin
            stack_we0 = 1'b1;
            if (sp_ff + SP_W'(1) < SP_W'(STACK_DEPTH)) begin
               stack_we1 = 1'b1;
               sp_in     = sp_ff + SP_W'(2);
            end else begin
               sp_in = sp_ff + SP_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         keep_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         keep_ff      <= keep_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      i_ff         <= i_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      ta_ff        <= ta_in;
      va_ff        <= va_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      dv_ff        <= dv_in;
      dt_ff        <= dt_in;
      p1_ff        <= p1_in;
      p2_ff        <= p2_in;
      lim_ff       <= lim_in;
      out_value_ff <= out_value_in;
      out_index_ff <= out_index_in;
      out_last_ff  <= out_last_in;
      if (stack_we0) begin
         stack_ff[sp_ff[SP_W-2:0]] <= stack_wr0;
      end
      if (stack_we1) begin
         stack_ff[sp_ff[SP_W-2:0] + 1'b1] <= stack_wr1;
      end
   end

   // sample memories, two registered read ports
   always_ff @(posedge clock) begin
      if (pop) begin
         val_mem[pop_data.idx[AW-1:0]]  <= pop_data.value;
         time_mem[pop_data.idx[AW-1:0]] <= pop_data.time_abs;
      end
      rd_val_a_ff  <= val_mem[addr_a];
      rd_time_a_ff <= time_mem[addr_a];
      rd_val_b_ff  <= val_mem[addr_b];
      rd_time_b_ff <= time_mem[addr_b];
   end

   `WBLS_ASSERT_SAME(a_stack_bound, clock, reset, 1'b1, sp_ff <= SP_W'(STACK_DEPTH), "segment stack overflow")
   `WBLS_ASSERT_SAME(a_out_state, clock, reset, out_valid_ff, state_ff == ST_OUT, "result shown outside output state")
   `WBLS_ASSERT_NEXT(a_close_eval, clock, reset, pop && pop_data.close, state_ff == ST_POP, "closed window did not start bisection")

endmodule

// ----- hdl/window_bisect_line_simplifier.sv -----
// ----------------------------------------------------------------------------
// window bisect line simplifier
// piecewise-linear window simplification by recursive bisection
// ----------------------------------------------------------------------------
//
//  channel   direction   handshake              payload
//  req       in          req_tvalid/req_tready  tdata {sample_value, time_delta}, tlast end_window
//  rsp       out         rsp_tvalid/rsp_tready  tdata {kept_index, kept_value}, tlast last_kept
//  csr       in          csr_valid/csr_ready    csr_index, csr_data
//
//  the front takes one sample per cycle while the two-entry queue has room
//  the back stores one sample per cycle while it is idle; a closed window then
//  pops each segment, reads and loads the endpoints of a segment with interior
//  samples and tests each interior sample (read, load, multiply, compare),
//  then scans the indices and emits each kept sample, waiting out stalls
//  reset is synchronous; no memory clearing is needed after reset
//  the front keeps accepting while the back bisects or a result waits,
//  until the two-entry queue is full
//
module window_bisect_line_simplifier #(
   parameter int MAX_WINDOW = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // time_delta [15:0], sample_value [47:16]
   input  logic        req_tlast,   // end_window
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // kept_value [31:0], kept_index [37:32], zeros
   output logic        rsp_tlast,   // last_kept
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_data
);
   import wbls_pkg::*;

   // configuration registers
   logic [CNT_W-1:0] window_len_ff;
   logic [EPS_W-1:0] epsilon_ff;

   // front to back queue
   sample_type q_push_data, q_pop_data;
   logic       q_push, q_pop, q_full, q_empty;

   logic [VAL_W-1:0] kept_value;
   logic [IDX_W-1:0] kept_index;

   // config writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= CNT_W'(64);
         epsilon_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_WINDOW_LEN) begin
            window_len_ff <= csr_data[CNT_W-1:0];
         end
         if (csr_index == CSR_EPSILON) begin
            epsilon_ff <= csr_data;
         end
      end
   end

   // front: time accumulation and window close decision
   wbls_front #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .window_len   (window_len_ff),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .time_delta   (req_tdata[15:0]),
      .sample_value (req_tdata[47:16]),
      .end_window   (req_tlast),
      .push         (q_push),
      .push_data    (q_push_data),
      .full         (q_full)
   );

   wbls_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_pop_data)
   );

   // back: sample store, bisection engine, result transfer
   wbls_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .epsilon    (epsilon_ff),
      .empty      (q_empty),
      .pop_data   (q_pop_data),
      .pop        (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .kept_value (kept_value),
      .kept_index (kept_index),
      .last_kept  (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, kept_index, kept_value};

endmodule

// ----- tb/window_bisect_line_simplifier_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// window bisect line simplifier test
// streams sample windows through the simplifier, predicts the kept points by
// bisecting each window locally and checks every result transfer in order
// ----------------------------------------------------------------------------
module window_bisect_line_simplifier_test;
   import wbls_pkg::*;

   localparam int MAX_WIN    = 64;
   localparam int STK_DEPTH  = 8;
   localparam int IDLE_LIMIT = 40000;   // cycles with no transfer at all
   localparam int QUIET_WAIT = 400;     // drain time for samples that cause no result

   typedef struct packed {
      logic [31:0] value;
      logic [5:0]  index;
      logic        last;
   } kept_point_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;    // time_delta [15:0], sample_value [47:16]
   logic        req_tlast;    // end_window
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // kept_value [31:0], kept_index [37:32], zeros
   logic        rsp_tlast;    // last_kept
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [30:0] csr_data;

   window_bisect_line_simplifier #(.MAX_WINDOW(MAX_WIN)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // local copy of the simplifier state
   logic [6:0]        cfg_window_len;
   logic [30:0]       cfg_epsilon;
   logic signed [31:0] win_value [MAX_WIN];
   logic [21:0]       win_time [MAX_WIN];
   int unsigned       win_fill;
   logic [11:0]       seg_stack [STK_DEPTH];
   int unsigned       seg_count;
   logic [63:0]       kept_mask;

   kept_point_type kept_queue [$];

   int error_count;
   int samples_sent;
   int points_seen;
   int windows_closed;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_request;
   int hold_left;

   // ------------------------------------------------------------------
   // clock and watchdog
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   int idle_cycles;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", idle_cycles);
         $display("window_bisect_line_simplifier verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------
   function automatic int unsigned eff_len();
      if (cfg_window_len < 2) return 2;
      if (cfg_window_len > MAX_WIN) return MAX_WIN;
      return 32'(cfg_window_len);
   endfunction

   // true when segment a..b must be split
   function automatic bit chord_exceeded(int unsigned a, int unsigned b);
      longint ta, tb, dx, dy, lim, num;
      ta = longint'(win_time[a]);
      tb = longint'(win_time[b]);
      if (ta == tb) return 1;
      dx = tb - ta;
      if (dx < 0) dx = -dx;
      dy = longint'(win_value[b]) - longint'(win_value[a]);
      lim = longint'(cfg_epsilon) * dx;
      for (int unsigned i = a + 1; i < b; i++) begin
         num = (longint'(win_value[i]) - longint'(win_value[a])) * dx
             - dy * (longint'(win_time[i]) - ta);
         if (tb < ta) num = -num;
         if (num < 0) num = -num;
         if (num > lim) return 1;
      end
      return 0;
   endfunction

   // segments beyond the stack depth are dropped, as in the block
   function automatic void seg_push(int unsigned a, int unsigned b);
      if (seg_count < STK_DEPTH) begin
         seg_stack[seg_count] = {a[5:0], b[5:0]};
         seg_count++;
      end
   endfunction

   function automatic void bisect_window();
      int unsigned a, b, m, total, n;
      kept_point_type pt;
      kept_mask = '0;
      seg_count = 0;
      seg_push(0, win_fill - 1);
      while (seg_count > 0) begin
         seg_count--;
         a = seg_stack[seg_count][11:6];
         b = seg_stack[seg_count][5:0];
         kept_mask[a] = 1'b1;
         kept_mask[b] = 1'b1;
         if (a + 1 < b && chord_exceeded(a, b)) begin
            m = (a + b) >> 1;
            seg_push(m, b);
            seg_push(a, m);
         end
      end
      total = 0;
      for (int unsigned i = 0; i < win_fill; i++) if (kept_mask[i]) total++;
      n = 0;
      for (int unsigned i = 0; i < win_fill; i++) begin
         if (kept_mask[i]) begin
            pt.value = win_value[i];
            pt.index = i[5:0];
            pt.last  = (n + 1 == total);
            kept_queue = {kept_queue, pt};
            n++;
         end
      end
      windows_closed++;
   endfunction

   function automatic void store_sample(logic [15:0] delta, logic [31:0] value, logic close);
      if (win_fill >= MAX_WIN) win_fill = 0;
      win_time[win_fill]  = (win_fill == 0) ? 22'd0 : win_time[win_fill-1] + 22'(delta);
      win_value[win_fill] = value;
      win_fill++;
      if (close || win_fill >= eff_len()) begin
         bisect_window();
         win_fill = 0;
      end
   endfunction

   // ------------------------------------------------------------------
   // result side: ready pattern, long hold-off and checking
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      kept_point_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         points_seen++;
         if (kept_queue.size() == 0) begin
            report_mismatch("unexpected result transfer, index", rsp_tdata[37:32], 0);
         end else begin
            want = kept_queue.pop_front();
            if (rsp_tdata[31:0] !== want.value)
               report_mismatch("kept_value", rsp_tdata[31:0], want.value);
            if (rsp_tdata[37:32] !== want.index)
               report_mismatch("kept_index", rsp_tdata[37:32], want.index);
            if (rsp_tlast !== want.last)
               report_mismatch("last_kept", rsp_tlast, want.last);
         end
      end
   end

   // ------------------------------------------------------------------
   // sample side
   // ------------------------------------------------------------------
   // one sample transfer; entered and left at a falling edge
   // each cycle before the offer is idle with the sender idle percentage
   task automatic send_sample(logic [15:0] delta, logic [31:0] value, logic close);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tdata  <= {value, delta};
      req_tlast  <= close;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      store_sample(delta, value, close);
      samples_sent++;
      @(negedge clock);
   endtask

   // drop valid, then wait until every predicted point has arrived and the
   // block has had time to store any trailing samples
   task automatic drain();
      req_tvalid <= 1'b0;
      while (kept_queue.size() != 0) @(negedge clock);
      repeat (QUIET_WAIT) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [30:0] data);
      drain();
      csr_index <= index;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_WINDOW_LEN) cfg_window_len = data[6:0];
      else if (index == CSR_EPSILON) cfg_epsilon = data;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // noisy line so that bisection goes a few levels deep
   task automatic send_window(int unsigned len, bit close_early);
      longint base, slope, noise, v;
      logic [15:0] d;
      int shape;
      base  = longint'($signed($urandom()));
      slope = longint'($urandom_range(0, 2000)) - 1000;
      noise = longint'(1) << $urandom_range(0, 30);
      shape = $urandom_range(0, 9);
      for (int unsigned i = 0; i < len; i++) begin
         case (shape)
            0: d = 16'($urandom());
            1: d = 16'd0;
            2: d = 16'hffff;
            default: d = 16'($urandom_range(0, 40));
         endcase
         if (shape == 3) v = longint'($signed($urandom()));
         else v = base + slope * i * 1000 + longint'($urandom_range(0, 1000)) * noise / 1000;
         send_sample(d, v[31:0], close_early && (i == len - 1));
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_directed();
      // single-sample window closed by the end flag
      send_sample(16'd5, 32'h7fffffff, 1'b1);
      // extremes of value and delta in a short closed window
      send_sample(16'hffff, 32'h80000000, 1'b0);
      send_sample(16'hffff, 32'h7fffffff, 1'b0);
      send_sample(16'h0000, 32'h00000000, 1'b0);
      send_sample(16'h8000, 32'hffffffff, 1'b1);
      // equal endpoint times force splits
      for (int i = 0; i < 5; i++) send_sample(16'd0, 32'(i * 7), i == 4);
      // largest epsilon keeps only the endpoints of a straight window
      write_reg(CSR_EPSILON, 31'h7fffffff);
      for (int i = 0; i < 6; i++) send_sample(16'd3, 32'(i * 100 + 5), i == 5);
      write_reg(CSR_EPSILON, 31'd0);
      // window length lowered below the current fill
      write_reg(CSR_WINDOW_LEN, 31'd8);
      for (int i = 0; i < 3; i++) send_sample(16'd2, 32'(i * i), 1'b0);
      write_reg(CSR_WINDOW_LEN, 31'd2);
      send_sample(16'd2, 32'd50, 1'b0);
      // lengths below two act as two
      write_reg(CSR_WINDOW_LEN, 31'd0);
      send_sample(16'd1, 32'd1, 1'b0);
      send_sample(16'd1, 32'd2, 1'b0);
      write_reg(CSR_WINDOW_LEN, 31'd1);
      send_sample(16'd1, 32'd3, 1'b0);
      send_sample(16'd1, 32'd4, 1'b0);
   endtask

   task automatic test_random_phase(int idle_pct, int stall_pct, int count);
      int start;
      int unsigned len;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      start = samples_sent;
      while (samples_sent - start < count) begin
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
               0: write_reg(CSR_EPSILON, 31'd0);
               1: write_reg(CSR_EPSILON, 31'h7fffffff);
               2: write_reg(CSR_EPSILON, 31'($urandom()));
               default: write_reg(CSR_EPSILON, 31'(1 << $urandom_range(0, 30)));
            endcase
            case ($urandom_range(0, 5))
               0: write_reg(CSR_WINDOW_LEN, 31'd64);
               1: write_reg(CSR_WINDOW_LEN, 31'($urandom_range(65, 127)));
               2: write_reg(CSR_WINDOW_LEN, 31'd2);
               default: write_reg(CSR_WINDOW_LEN, 31'($urandom_range(3, 16)));
            endcase
         end
         len = $urandom_range(1, (eff_len() > 16) ? 16 : eff_len());
         if ($urandom_range(0, 9) == 0) len = eff_len();
         // mostly closed windows; some fill up or run past on raw noise
         if ($urandom_range(0, 7) == 0)
            send_sample(16'($urandom()), $urandom(), 1'($urandom_range(0, 1)));
         else
            send_window(len, $urandom_range(0, 4) != 0);
      end
      drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_reg(CSR_WINDOW_LEN, 31'd4);
      write_reg(CSR_EPSILON, 31'd0);
      hold_request = 1500;
      for (int i = 0; i < 40; i++) send_sample(16'($urandom_range(1, 9)), $urandom(), 1'b0);
      drain();
   endtask

   task automatic test_full_window();
      send_idle_pct  = 10;
      recv_stall_pct = 10;
      write_reg(CSR_WINDOW_LEN, 31'd64);
      write_reg(CSR_EPSILON, 31'd0);
      send_window(64, 1'b0);
      drain();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      cfg_window_len = 7'd64;
      cfg_epsilon    = '0;
      win_fill = 0;
      seg_count = 0;
      kept_mask = '0;
      error_count = 0;
      samples_sent = 0;
      points_seen = 0;
      windows_closed = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 0;
      hold_left = 0;
      idle_cycles = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed();
      drain();
      test_random_phase(0, 0, 80);
      test_random_phase(86, 0, 80);
      test_random_phase(0, 86, 80);
      test_random_phase(10, 10, 80);
      test_backpressure();
      test_full_window();

      drain();
      $display("covered %0d samples in %0d windows, %0d kept points checked",
               samples_sent, windows_closed, points_seen);
      $display("phases: directed cases, four idle mixes, long output hold, full window");
      if (error_count == 0) begin
         $display("window_bisect_line_simplifier verification clean");
      end else begin
         $display("%0d mismatches", error_count);
         $display("window_bisect_line_simplifier verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/wbls_pkg.sv
hdl/wbls_queue.sv
hdl/wbls_front.sv
hdl/wbls_back.sv
hdl/window_bisect_line_simplifier.sv
tb/window_bisect_line_simplifier_test.sv
